@@ hdl/calendar_bucket_time_accumulator_core_assert.svh @@
// ----------------------------------------------------------------------------
// Calendar bucket accumulator assertion macros
// Concurrent assertion wrappers; they compile to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_BUCKET_TIME_ACCUMULATOR_CORE_ASSERT_SVH
`define CALENDAR_BUCKET_TIME_ACCUMULATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define CBTA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define CBTA_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CBTA_ASSERT(lbl, clk, rstn, prop, msg)
`define CBTA_ASSERT_NR(lbl, clk, prop, msg)
`endif

`endif

@@ hdl/cbta_pkg.sv @@
// ----------------------------------------------------------------------------
// Calendar bucket accumulator package
// Widths, field positions and the structs shared between the block's modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cbta_pkg;

  localparam int DAY_W       = 20;
  localparam int SEC_W       = 17;
  localparam int WORD_W      = 32;
  localparam int WTAG_W      = 18;
  localparam int MTAG_W      = 16;
  localparam int YTAG_W      = 12;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 7 * WORD_W;

  localparam int DIV_CNT_W = 5;
  localparam logic [DIV_CNT_W-1:0] DIV_LONG_STEPS = DIV_CNT_W'(WORD_W / 2);

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] dividend;
    logic [WORD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [WORD_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic              en;
    logic [DAY_W-1:0]  day;
    logic [WTAG_W-1:0] wtag;
    logic [MTAG_W-1:0] mtag;
    logic [YTAG_W-1:0] ytag;
    logic [SEC_W-1:0]  secs;
  } bkt_upd_t;

  typedef struct packed {
    logic [WORD_W-1:0] total;
    logic [WORD_W-1:0] today;
    logic [WORD_W-1:0] week;
    logic [WORD_W-1:0] month;
    logic [WORD_W-1:0] year;
  } bkt_view_t;

endpackage

@@ hdl/cbta_div.sv @@
// ----------------------------------------------------------------------------
// Calendar bucket accumulator shared divider
// Restoring unsigned divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cbta_div (
  input  logic              clk,
  input  logic              rst_n,
  input  cbta_pkg::div_req_t req,
  output cbta_pkg::div_rsp_t rsp
);

  localparam int W = cbta_pkg::WORD_W;

  logic [W-1:0]                   rem_r;
  logic [W-1:0]                   q_r;
  logic [W-1:0]                   dvs_r;
  logic [cbta_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                           busy_r;
  logic                           done_r;

  logic [W:0]   t1, t2, d_ext;
  logic         ge1, ge2;
  logic [W-1:0] rem1, rem_nxt, q_nxt;

  always_comb begin
    d_ext   = {1'b0, dvs_r};
    t1      = {rem_r, q_r[W-1]};
    ge1     = (t1 >= d_ext);
    rem1    = ge1 ? W'(t1 - d_ext) : t1[W-1:0];
    t2      = {rem1, q_r[W-2]};
    ge2     = (t2 >= d_ext);
    rem_nxt = ge2 ? W'(t2 - d_ext) : t2[W-1:0];
    q_nxt   = {q_r[W-3:0], ge1, ge2};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (busy_r) begin
        rem_r <= rem_nxt;
        q_r   <= q_nxt;
        cnt_r <= cnt_r - cbta_pkg::DIV_CNT_W'(1);
        if (cnt_r == cbta_pkg::DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end else if (req.start) begin
        rem_r  <= '0;
        dvs_r  <= req.divisor;
        busy_r <= 1'b1;
        q_r    <= req.dividend;
        cnt_r  <= cbta_pkg::DIV_LONG_STEPS;
      end
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = q_r;

endmodule

@@ hdl/cbta_buckets.sv @@
// ----------------------------------------------------------------------------
// Calendar bucket accumulator bucket store
// Day, week, month and year buckets with their tags, plus the grand total.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cbta_buckets (
  input  logic                clk,
  input  logic                rst_n,
  input  cbta_pkg::bkt_upd_t  upd,
  output cbta_pkg::bkt_view_t view
);

  localparam int W = cbta_pkg::WORD_W;

  logic [cbta_pkg::DAY_W-1:0]  day_tag_r;
  logic [cbta_pkg::WTAG_W-1:0] week_tag_r;
  logic [cbta_pkg::MTAG_W-1:0] month_tag_r;
  logic [cbta_pkg::YTAG_W-1:0] year_tag_r;
  logic [W-1:0]                day_sum_r, week_sum_r, month_sum_r, year_sum_r, total_r;

  logic         day_hit, week_hit, month_hit, year_hit;
  logic [W-1:0] secs_ext;

  always_comb begin
    day_hit   = (day_tag_r == upd.day);
    week_hit  = (week_tag_r == upd.wtag);
    month_hit = (month_tag_r == upd.mtag);
    year_hit  = (year_tag_r == upd.ytag);
    secs_ext  = W'(upd.secs);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      day_tag_r   <= '0;
      week_tag_r  <= '0;
      month_tag_r <= '0;
      year_tag_r  <= '0;
      day_sum_r   <= '0;
      week_sum_r  <= '0;
      month_sum_r <= '0;
      year_sum_r  <= '0;
      total_r     <= '0;
    end else if (upd.en) begin
      // roll a stale bucket to the new index, then add
      day_tag_r   <= upd.day;
      week_tag_r  <= upd.wtag;
      month_tag_r <= upd.mtag;
      year_tag_r  <= upd.ytag;
      day_sum_r   <= (day_hit   ? day_sum_r   : '0) + secs_ext;
      week_sum_r  <= (week_hit  ? week_sum_r  : '0) + secs_ext;
      month_sum_r <= (month_hit ? month_sum_r : '0) + secs_ext;
      year_sum_r  <= (year_hit  ? year_sum_r  : '0) + secs_ext;
      total_r     <= total_r + secs_ext;
    end
  end

  assign view.total = total_r;
  assign view.today = day_hit   ? day_sum_r   : '0;
  assign view.week  = week_hit  ? week_sum_r  : '0;
  assign view.month = month_hit ? month_sum_r : '0;
  assign view.year  = year_hit  ? year_sum_r  : '0;

endmodule

@@ hdl/calendar_bucket_time_accumulator_core.sv @@
// ----------------------------------------------------------------------------
// Calendar bucket time accumulator core
// Sequencer around one shared divider and the bucket store.
// ----------------------------------------------------------------------------
// Each input transaction goes through the following steps from acceptance until
// its result is loaded into the output register: the week, month and year
// indices from a reciprocal multiply of the day number, one at a time, the
// bucket update, the view capture, two divisions for the daily and weekly
// averages (16 steps each of the shared two-bit-per-cycle divider plus
// handoff) and the load, which waits until the output register is free.
// in_tready is high only while the sequencer is idle, so a new transaction
// is not accepted until the last one is through; a finished result waits in
// the output register while the next transaction is accepted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "calendar_bucket_time_accumulator_core_assert.svh"

module calendar_bucket_time_accumulator_core #(
  parameter int unsigned DAYS_PER_WEEK  = 7,
  parameter int unsigned DAYS_PER_MONTH = 30,
  parameter int unsigned DAYS_PER_YEAR  = 365
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [19:0] day, [36:20] session_seconds, [39:37] zero
  input  logic [cbta_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [31:0] total_time, [63:32] today_time, [95:64] week_time,
  // [127:96] month_time, [159:128] year_time, [191:160] avg_daily,
  // [223:192] avg_weekly
  output logic [cbta_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  localparam int W  = cbta_pkg::WORD_W;
  localparam int DW = cbta_pkg::DAY_W;
  localparam int SW = cbta_pkg::SEC_W;
  localparam int RK = 30;
  localparam int RW = 31;

  localparam logic [RW-1:0] WK_RECIP =
    RW'(((64'd1 << RK) + 64'(DAYS_PER_WEEK) - 64'd1) / 64'(DAYS_PER_WEEK));
  localparam logic [RW-1:0] MO_RECIP =
    RW'(((64'd1 << RK) + 64'(DAYS_PER_MONTH) - 64'd1) / 64'(DAYS_PER_MONTH));
  localparam logic [RW-1:0] YR_RECIP =
    RW'(((64'd1 << RK) + 64'(DAYS_PER_YEAR) - 64'd1) / 64'(DAYS_PER_YEAR));

  typedef enum logic [3:0] {
    S_IDLE, S_WK, S_MO, S_YR, S_UPD, S_VIEW, S_AD, S_AW, S_OUT
  } state_t;

  state_t              state_r;
  logic [DW-1:0]       day_r;
  logic [SW-1:0]       secs_r;
  logic [DW-1:0]       wk_r, mo_r, yr_r;
  logic [W-1:0]        ad_r;
  cbta_pkg::bkt_view_t res_r;
  cbta_pkg::div_req_t  div_req_r;
  cbta_pkg::div_rsp_t  div_rsp;
  cbta_pkg::bkt_upd_t  upd;
  cbta_pkg::bkt_view_t view;
  logic                out_tvalid_r;
  logic [cbta_pkg::OUT_TDATA_W-1:0] out_tdata_r;
  logic [RW-1:0]       recip;
  logic [DW+RW-1:0]    prod;
  logic [DW-1:0]       quot;

  cbta_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req_r),
    .rsp   (div_rsp)
  );

  always_comb begin
    case (state_r)
      S_WK:    recip = WK_RECIP;
      S_MO:    recip = MO_RECIP;
      default: recip = YR_RECIP;
    endcase
    prod = {{RW{1'b0}}, day_r} * {{DW{1'b0}}, recip};
    quot = prod[RK+DW-1:RK];
  end

  always_comb begin
    upd.en   = (state_r == S_UPD) && (secs_r != '0);
    upd.day  = day_r;
    upd.wtag = wk_r[cbta_pkg::WTAG_W-1:0];
    upd.mtag = mo_r[cbta_pkg::MTAG_W-1:0];
    upd.ytag = yr_r[cbta_pkg::YTAG_W-1:0];
    upd.secs = secs_r;
  end

  cbta_buckets u_bkt (
    .clk   (clk),
    .rst_n (rst_n),
    .upd   (upd),
    .view  (view)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      out_tvalid_r    <= 1'b0;
      div_req_r.start <= 1'b0;
    end else begin
      out_tvalid_r <= (state_r == S_OUT) || (out_tvalid_r && !out_tready);
      unique case (state_r)
        S_IDLE: begin
          div_req_r.start <= 1'b0;
          if (in_tvalid) begin
            day_r   <= in_tdata[DW-1:0];
            secs_r  <= in_tdata[DW+SW-1:DW];
            state_r <= S_WK;
          end
        end
        S_WK: begin
          div_req_r.start <= 1'b0;
          wk_r            <= quot;
          state_r         <= S_MO;
        end
        S_MO: begin
          div_req_r.start <= 1'b0;
          mo_r            <= quot;
          state_r         <= S_YR;
        end
        S_YR: begin
          div_req_r.start <= 1'b0;
          yr_r            <= quot;
          state_r         <= S_UPD;
        end
        S_UPD: begin
          div_req_r.start <= 1'b0;
          state_r         <= S_VIEW;
        end
        S_VIEW: begin
          res_r              <= view;
          div_req_r.start    <= 1'b1;
          div_req_r.dividend <= view.total;
          div_req_r.divisor  <= W'(day_r) + W'(1);
          state_r            <= S_AD;
        end
        S_AD: begin
          div_req_r.start <= div_rsp.done;
          if (div_rsp.done) begin
            ad_r               <= div_rsp.quotient;
            div_req_r.dividend <= res_r.total;
            div_req_r.divisor  <= W'(wk_r) + W'(1);
            state_r            <= S_AW;
          end
        end
        S_AW: begin
          div_req_r.start <= 1'b0;
          if (div_rsp.done) begin
            out_tdata_r[W-1:0]     <= res_r.total;
            out_tdata_r[2*W-1:W]   <= res_r.today;
            out_tdata_r[3*W-1:2*W] <= res_r.week;
            out_tdata_r[4*W-1:3*W] <= res_r.month;
            out_tdata_r[5*W-1:4*W] <= res_r.year;
            out_tdata_r[6*W-1:5*W] <= ad_r;
            out_tdata_r[7*W-1:6*W] <= div_rsp.quotient;
            state_r                <= S_OUT;
          end
        end
        S_OUT: begin
          div_req_r.start <= 1'b0;
          if (!out_tvalid_r || out_tready) begin
            out_tdata <= out_tdata_r;
            state_r   <= S_IDLE;
          end
        end
        default: begin
          div_req_r.start <= 1'b0;
          state_r         <= S_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;

  `CBTA_ASSERT(a_accept_starts_week, clk, rst_n, in_tvalid && in_tready |=> state_r == S_WK, "accepted transaction did not start the week step")
  `CBTA_ASSERT(a_busy_not_ready, clk, rst_n, div_rsp.busy |-> !in_tready, "input ready while the divider is busy")
  `CBTA_ASSERT(a_done_in_wait, clk, rst_n, div_rsp.done |-> state_r == S_AD || state_r == S_AW, "divider finished outside a division wait state")
  `CBTA_ASSERT(a_out_load, clk, rst_n, state_r == S_OUT && (!out_tvalid_r || out_tready) |=> out_tvalid_r && state_r == S_IDLE, "result not presented after load")

endmodule
